// File: hw/rtl/i2cee_pkg.sv
// Shared types and constants for the I2C EEPROM byte access master.
// Holds the phase encoding, configuration indexes and the per-tick result struct.
// No dependencies.
package i2cee_pkg;

    localparam int unsigned CfgIdxW  = 1;
    localparam int unsigned CfgDataW = 8;

    localparam logic [CfgIdxW-1:0] CFG_ACK_WAIT_LIMIT = 1'b0;
    localparam logic [CfgIdxW-1:0] CFG_DEVICE_ADDRESS = 1'b1;

    localparam logic [7:0] ACK_WAIT_LIMIT_RST = 8'd250;
    localparam logic [6:0] DEVICE_ADDRESS_RST = 7'd80;

    localparam logic [1:0] CMD_TICK  = 2'd0;
    localparam logic [1:0] CMD_WRITE = 2'd1;
    localparam logic [1:0] CMD_READ  = 2'd2;

    // Byte position within a transaction
    localparam logic [1:0] STAGE_DEVICE = 2'd0;
    localparam logic [1:0] STAGE_WORD   = 2'd1;
    localparam logic [1:0] STAGE_DATA   = 2'd2;

    localparam logic [2:0] LAST_BIT = 3'd7;

    typedef enum logic [4:0] {
        PH_IDLE        = 5'd0,
        PH_ST_SDA_HI   = 5'd1,
        PH_ST_SCL_HI   = 5'd2,
        PH_ST_SDA_LO   = 5'd3,
        PH_WB_SCL_LO   = 5'd4,
        PH_WB_SDA      = 5'd5,
        PH_WB_SCL_HI   = 5'd6,
        PH_WB_END_LO   = 5'd7,
        PH_WB_END_REL  = 5'd8,
        PH_ACK_HI      = 5'd9,
        PH_ACK_WAIT    = 5'd10,
        PH_RB_SCL_LO   = 5'd11,
        PH_RB_REL      = 5'd12,
        PH_RB_SCL_HI   = 5'd13,
        PH_RB_SAMPLE   = 5'd14,
        PH_NACK_HI     = 5'd15,
        PH_NACK_LO     = 5'd16,
        PH_STOP_SDA_LO = 5'd17,
        PH_STOP_SCL_HI = 5'd18,
        PH_STOP_SDA_HI = 5'd19
    } t_phase;

    typedef struct packed {
        logic       ack_missing;
        logic [7:0] read_data;
        logic       done_res;
        logic       busy_res;
        logic       sda_out;
        logic       scl_out;
    } t_result;

endpackage

// File: hw/rtl/i2cee_ctrl.sv
// Bus sequencer: advances the I2C phase machine by one tick per accepted request
// and produces the pin levels and status for that tick. Uses i2cee_pkg.
module i2cee_ctrl (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_step,
    input  logic [1:0]                          i_command,
    input  logic [7:0]                          i_word_address,
    input  logic [7:0]                          i_write_data,
    input  logic                                i_sda_in,
    input  logic                                i_cfg_we,
    input  logic [i2cee_pkg::CfgIdxW-1:0]       i_cfg_idx,
    input  logic [i2cee_pkg::CfgDataW-1:0]      i_cfg_data,
    output i2cee_pkg::t_result                  o_result
);

    i2cee_pkg::t_phase r_phase, n_phase;
    logic [2:0] r_bit_index, n_bit_index;
    logic [7:0] r_shift, n_shift;
    logic [7:0] r_wait_count, n_wait_count;
    logic [7:0] r_held_address, n_held_address;
    logic [7:0] r_held_data, n_held_data;
    logic       r_is_read, n_is_read;
    logic       r_timeout, n_timeout;
    logic       r_scl, n_scl;
    logic       r_sda, n_sda;
    logic [1:0] r_stage, n_stage;
    logic [7:0] r_last_read, n_last_read;
    logic [7:0] r_ack_wait_limit;
    logic [6:0] r_device_address;
    logic       done;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ack_wait_limit <= i2cee_pkg::ACK_WAIT_LIMIT_RST;
            r_device_address <= i2cee_pkg::DEVICE_ADDRESS_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                i2cee_pkg::CFG_ACK_WAIT_LIMIT: r_ack_wait_limit <= i_cfg_data;
                i2cee_pkg::CFG_DEVICE_ADDRESS: r_device_address <= i_cfg_data[6:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase        <= i2cee_pkg::PH_IDLE;
            r_bit_index    <= '0;
            r_shift        <= '0;
            r_wait_count   <= '0;
            r_held_address <= '0;
            r_held_data    <= '0;
            r_is_read      <= 1'b0;
            r_timeout      <= 1'b0;
            r_scl          <= 1'b1;
            r_sda          <= 1'b1;
            r_stage        <= i2cee_pkg::STAGE_DEVICE;
            r_last_read    <= '0;
        end else if (i_step) begin
            r_phase        <= n_phase;
            r_bit_index    <= n_bit_index;
            r_shift        <= n_shift;
            r_wait_count   <= n_wait_count;
            r_held_address <= n_held_address;
            r_held_data    <= n_held_data;
            r_is_read      <= n_is_read;
            r_timeout      <= n_timeout;
            r_scl          <= n_scl;
            r_sda          <= n_sda;
            r_stage        <= n_stage;
            r_last_read    <= n_last_read;
        end
    end

    always_comb begin
        n_phase        = r_phase;
        n_bit_index    = r_bit_index;
        n_shift        = r_shift;
        n_wait_count   = r_wait_count;
        n_held_address = r_held_address;
        n_held_data    = r_held_data;
        n_is_read      = r_is_read;
        n_timeout      = r_timeout;
        n_scl          = r_scl;
        n_sda          = r_sda;
        n_stage        = r_stage;
        n_last_read    = r_last_read;
        done           = 1'b0;

        unique case (r_phase)
            i2cee_pkg::PH_IDLE: begin
                if (i_command == i2cee_pkg::CMD_WRITE || i_command == i2cee_pkg::CMD_READ) begin
                    n_held_address = i_word_address;
                    n_held_data    = i_write_data;
                    n_is_read      = (i_command == i2cee_pkg::CMD_READ);
                    n_timeout      = 1'b0;
                    n_stage        = i2cee_pkg::STAGE_DEVICE;
                    n_phase        = i2cee_pkg::PH_ST_SDA_HI;
                end
            end
            i2cee_pkg::PH_ST_SDA_HI: begin
                n_sda   = 1'b1;
                n_phase = i2cee_pkg::PH_ST_SCL_HI;
            end
            i2cee_pkg::PH_ST_SCL_HI: begin
                n_scl   = 1'b1;
                n_phase = i2cee_pkg::PH_ST_SDA_LO;
            end
            i2cee_pkg::PH_ST_SDA_LO: begin
                // Read bit set on the repeated start
                n_sda       = 1'b0;
                n_shift     = {r_device_address, (r_stage != i2cee_pkg::STAGE_DEVICE)};
                n_bit_index = '0;
                n_phase     = i2cee_pkg::PH_WB_SCL_LO;
            end
            i2cee_pkg::PH_WB_SCL_LO: begin
                n_scl   = 1'b0;
                n_phase = i2cee_pkg::PH_WB_SDA;
            end
            i2cee_pkg::PH_WB_SDA: begin
                n_sda   = r_shift[~r_bit_index];
                n_phase = i2cee_pkg::PH_WB_SCL_HI;
            end
            i2cee_pkg::PH_WB_SCL_HI: begin
                n_scl = 1'b1;
                if (r_bit_index == i2cee_pkg::LAST_BIT) begin
                    n_phase = i2cee_pkg::PH_WB_END_LO;
                end else begin
                    n_bit_index = r_bit_index + 3'd1;
                    n_phase     = i2cee_pkg::PH_WB_SCL_LO;
                end
            end
            i2cee_pkg::PH_WB_END_LO: begin
                n_scl   = 1'b0;
                n_phase = i2cee_pkg::PH_WB_END_REL;
            end
            i2cee_pkg::PH_WB_END_REL: begin
                n_sda   = 1'b1;
                n_phase = i2cee_pkg::PH_ACK_HI;
            end
            i2cee_pkg::PH_ACK_HI: begin
                n_scl        = 1'b1;
                n_wait_count = '0;
                n_phase      = i2cee_pkg::PH_ACK_WAIT;
            end
            i2cee_pkg::PH_ACK_WAIT: begin
                if (!i_sda_in || r_wait_count >= r_ack_wait_limit) begin
                    if (i_sda_in) begin
                        n_timeout = 1'b1;
                    end
                    n_scl = 1'b0;
                    case (r_stage)
                        i2cee_pkg::STAGE_DEVICE: begin
                            n_stage     = i2cee_pkg::STAGE_WORD;
                            n_shift     = r_held_address;
                            n_bit_index = '0;
                            n_phase     = i2cee_pkg::PH_WB_SCL_LO;
                        end
                        i2cee_pkg::STAGE_WORD: begin
                            n_stage = i2cee_pkg::STAGE_DATA;
                            if (r_is_read) begin
                                n_phase = i2cee_pkg::PH_ST_SDA_HI;
                            end else begin
                                n_shift     = r_held_data;
                                n_bit_index = '0;
                                n_phase     = i2cee_pkg::PH_WB_SCL_LO;
                            end
                        end
                        default: begin
                            n_phase = r_is_read ? i2cee_pkg::PH_RB_SCL_LO
                                                : i2cee_pkg::PH_STOP_SDA_LO;
                        end
                    endcase
                end else begin
                    n_wait_count = r_wait_count + 8'd1;
                end
            end
            i2cee_pkg::PH_RB_SCL_LO: begin
                n_scl   = 1'b0;
                n_phase = i2cee_pkg::PH_RB_REL;
            end
            i2cee_pkg::PH_RB_REL: begin
                n_sda       = 1'b1;
                n_shift     = '0;
                n_bit_index = '0;
                n_phase     = i2cee_pkg::PH_RB_SCL_HI;
            end
            i2cee_pkg::PH_RB_SCL_HI: begin
                n_scl   = 1'b1;
                n_phase = i2cee_pkg::PH_RB_SAMPLE;
            end
            i2cee_pkg::PH_RB_SAMPLE: begin
                n_shift = {r_shift[6:0], i_sda_in};
                n_scl   = 1'b0;
                if (r_bit_index == i2cee_pkg::LAST_BIT) begin
                    n_last_read = {r_shift[6:0], i_sda_in};
                    n_phase     = i2cee_pkg::PH_NACK_HI;
                end else begin
                    n_bit_index = r_bit_index + 3'd1;
                    n_phase     = i2cee_pkg::PH_RB_SCL_HI;
                end
            end
            i2cee_pkg::PH_NACK_HI: begin
                n_scl   = 1'b1;
                n_phase = i2cee_pkg::PH_NACK_LO;
            end
            i2cee_pkg::PH_NACK_LO: begin
                n_scl   = 1'b0;
                n_phase = i2cee_pkg::PH_STOP_SDA_LO;
            end
            i2cee_pkg::PH_STOP_SDA_LO: begin
                n_sda   = 1'b0;
                n_phase = i2cee_pkg::PH_STOP_SCL_HI;
            end
            i2cee_pkg::PH_STOP_SCL_HI: begin
                n_scl   = 1'b1;
                n_phase = i2cee_pkg::PH_STOP_SDA_HI;
            end
            i2cee_pkg::PH_STOP_SDA_HI: begin
                n_sda   = 1'b1;
                done    = 1'b1;
                n_phase = i2cee_pkg::PH_IDLE;
            end
            default: begin
                n_phase = i2cee_pkg::PH_IDLE;
            end
        endcase
    end

    always_comb begin
        o_result.scl_out     = n_scl;
        o_result.sda_out     = n_sda;
        o_result.busy_res    = (n_phase != i2cee_pkg::PH_IDLE);
        o_result.done_res    = done;
        o_result.read_data   = n_last_read;
        o_result.ack_missing = n_timeout;
    end

`ifndef SYNTHESIS
    // Stop completion always lands back in idle
    a_stop_to_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_step && r_phase == i2cee_pkg::PH_STOP_SDA_HI) |=> (r_phase == i2cee_pkg::PH_IDLE))
        else $error("stop did not return to idle");

    // Bus is released whenever the sequencer is idle
    a_idle_released: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == i2cee_pkg::PH_IDLE) |-> (r_scl && r_sda))
        else $error("bus not released while idle");

    // SCL is held high for the whole acknowledge wait
    a_ack_scl_high: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == i2cee_pkg::PH_ACK_WAIT) |-> r_scl)
        else $error("SCL low during acknowledge wait");

    // Last sampled bit completes the read byte
    a_read_capture: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_step && r_phase == i2cee_pkg::PH_RB_SAMPLE && r_bit_index == i2cee_pkg::LAST_BIT)
        |=> (r_last_read == {$past(r_shift[6:0]), $past(i_sda_in)}))
        else $error("read byte not captured");
`endif

endmodule

// File: hw/rtl/i2cee_out_buf.sv
// Output register with a skid stage for the per-tick result stream.
// Uses i2cee_pkg for the result struct.
module i2cee_out_buf (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    input  i2cee_pkg::t_result i_data,
    output logic               o_ready,
    output logic               o_valid,
    output i2cee_pkg::t_result o_data,
    input  logic               i_ready
);

    logic               r_out_valid;
    i2cee_pkg::t_result r_out;
    logic               r_skid_valid;
    i2cee_pkg::t_result r_skid;
    logic               out_free;

    assign out_free = !r_out_valid || i_ready;
    assign o_ready  = !r_skid_valid;
    assign o_valid  = r_out_valid;
    assign o_data   = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (out_free) begin
            // Drain the skid stage first; no request is taken while it is full
            if (r_skid_valid) begin
                r_out_valid  <= 1'b1;
                r_skid_valid <= 1'b0;
            end else begin
                r_out_valid <= i_valid;
            end
        end else if (i_valid) begin
            r_skid_valid <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_free) begin
            r_out <= r_skid_valid ? r_skid : i_data;
        end else if (i_valid && !r_skid_valid) begin
            r_skid <= i_data;
        end
    end

endmodule

// File: hw/rtl/i2c_eeprom_byte_access_master_core.sv
// I2C EEPROM byte access master: one bus tick per request, one result per request.
// Results are registered in the output stage, or held in the skid stage on a stall.
// Throughput: one request per cycle while the skid stage is empty. The phase machine
// resolves ticks combinationally; on a stall the skid stage holds one more request.
// Reset (synchronous, active low): idle, both lines released, registers at defaults.
// Depends on i2cee_pkg, i2cee_ctrl and i2cee_out_buf.
module i2c_eeprom_byte_access_master_core (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_s_axis_tvalid,
    output logic                           o_s_axis_tready,
    // [7:0] word_address, [15:8] write_data, [16] sda_in, [23:17] zero
    input  logic [23:0]                    i_s_axis_tdata,
    // [1:0] command
    input  logic [1:0]                     i_s_axis_tuser,
    output logic                           o_m_axis_tvalid,
    input  logic                           i_m_axis_tready,
    // [0] scl_out, [1] sda_out, [2] busy_res, [3] done_res, [11:4] read_data,
    // [12] ack_missing, [15:13] zero
    output logic [15:0]                    o_m_axis_tdata,
    input  logic                           i_cfg_we,
    input  logic [i2cee_pkg::CfgIdxW-1:0]  i_cfg_idx,
    input  logic [i2cee_pkg::CfgDataW-1:0] i_cfg_data
);

    logic               step;
    i2cee_pkg::t_result result;
    i2cee_pkg::t_result out_result;

    assign step = i_s_axis_tvalid && o_s_axis_tready;

    i2cee_ctrl u_ctrl (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_step         (step),
        .i_command      (i_s_axis_tuser),
        .i_word_address (i_s_axis_tdata[7:0]),
        .i_write_data   (i_s_axis_tdata[15:8]),
        .i_sda_in       (i_s_axis_tdata[16]),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_idx      (i_cfg_idx),
        .i_cfg_data     (i_cfg_data),
        .o_result       (result)
    );

    i2cee_out_buf u_out_buf (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (step),
        .i_data  (result),
        .o_ready (o_s_axis_tready),
        .o_valid (o_m_axis_tvalid),
        .o_data  (out_result),
        .i_ready (i_m_axis_tready)
    );

    assign o_m_axis_tdata = {3'b000, out_result};

endmodule
